// ===== src/mbet_pkg.sv =====
// Shared types, constants and helpers for the escape-time evaluator.
// Depends on nothing; every other file refers to it by scoped names.
package mbet_pkg;

    localparam int FRAC_BITS = 28;
    localparam int COORD_W   = 32;
    localparam int DIM_W     = 12;
    localparam int SIZE_W    = 13;
    localparam int ITER_W    = 16;
    localparam int PIX_W     = 24;
    localparam int CIDX_W    = 3;
    localparam int CDATA_W   = 32;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int MAG_W     = COORD_W + DIM_W + 1;
    localparam int DIV_STEPS = MAG_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int ESC_BIT   = 2 * FRAC_BITS + 2;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = $clog2(Q_DEPTH);

    typedef enum logic [CIDX_W-1:0] {
        CFG_X_START = 3'd0,
        CFG_X_END   = 3'd1,
        CFG_Y_START = 3'd2,
        CFG_Y_END   = 3'd3,
        CFG_WIDTH   = 3'd4,
        CFG_HEIGHT  = 3'd5,
        CFG_LIMIT   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_start;
        logic signed [COORD_W-1:0] x_end;
        logic signed [COORD_W-1:0] y_start;
        logic signed [COORD_W-1:0] y_end;
        logic [SIZE_W-1:0]         image_width;
        logic [SIZE_W-1:0]         image_height;
        logic [ITER_W-1:0]         iteration_limit;
    } t_cfg;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [PIX_W-1:0]          pix;
    } t_job;

    typedef struct packed {
        logic push;
        logic pop;
    } t_qctl;

    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi;
        logic signed [PROD_W-1:0] lo;
        hi = PROD_W'({1'b0, {(COORD_W-1){1'b1}}});
        lo = -hi - PROD_W'(1);
        if (v > hi) return hi[COORD_W-1:0];
        if (v < lo) return lo[COORD_W-1:0];
        return v[COORD_W-1:0];
    endfunction

endpackage

// ===== src/mbet_if.sv =====
// Handshake channels: pixel requests, results and register writes.
// Depends on mbet_pkg.
interface mbet_pix_if;
    logic                        valid;
    logic                        ready;
    logic [mbet_pkg::DIM_W-1:0]  column;
    logic [mbet_pkg::DIM_W-1:0]  row;
    modport source (output valid, column, row, input ready);
    modport sink   (input valid, column, row, output ready);
endinterface

interface mbet_res_if;
    logic                        valid;
    logic                        ready;
    logic [mbet_pkg::ITER_W-1:0] escape_count;
    logic [mbet_pkg::PIX_W-1:0]  pixel_index;
    modport source (output valid, escape_count, pixel_index, input ready);
    modport sink   (input valid, escape_count, pixel_index, output ready);
endinterface

interface mbet_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [mbet_pkg::CIDX_W-1:0]  index;
    logic [mbet_pkg::CDATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/mandelbrot_escape_time.sv =====
// Top level: register file, front end, job queue and iteration back end.
// Depends on mbet_pkg, mbet_if, mbet_front, mbet_queue, mbet_back.
//   channel  dir  payload                       accepted when
//   i_pix    in   column, row                   valid && ready
//   o_res    out  escape_count, pixel_index     valid && ready
//   i_cfg    in   index, data                   valid && ready (always ready)
// Front: maps each pixel with a one-bit-a-step 45-step divider and takes no new
// pixel until its job is pushed. Back: each iteration is a multiply, then a test and
// update, with the pop, the final test and the output around them.
// The four-entry queue lets the front map new pixels while the back iterates.
// Reset is synchronous; config and state registers return to their reset values.
module mandelbrot_escape_time (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbet_pix_if.sink    i_pix,
    mbet_res_if.source  o_res,
    mbet_cfg_if.sink    i_cfg
);
    mbet_pkg::t_cfg  r_cfg;
    mbet_pkg::t_job  front_job, queue_job;
    mbet_pkg::t_qctl qctl;
    logic            q_full, q_empty, push, pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.x_start         <= -32'sd536870912;
            r_cfg.x_end           <= 32'sd268435456;
            r_cfg.y_start         <= -32'sd402653184;
            r_cfg.y_end           <= 32'sd402653184;
            r_cfg.image_width     <= 13'd1024;
            r_cfg.image_height    <= 13'd1024;
            r_cfg.iteration_limit <= 16'd256;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                mbet_pkg::CFG_X_START: r_cfg.x_start <= i_cfg.data;
                mbet_pkg::CFG_X_END:   r_cfg.x_end   <= i_cfg.data;
                mbet_pkg::CFG_Y_START: r_cfg.y_start <= i_cfg.data;
                mbet_pkg::CFG_Y_END:   r_cfg.y_end   <= i_cfg.data;
                mbet_pkg::CFG_WIDTH:
                    r_cfg.image_width <= i_cfg.data[mbet_pkg::SIZE_W-1:0];
                mbet_pkg::CFG_HEIGHT:
                    r_cfg.image_height <= i_cfg.data[mbet_pkg::SIZE_W-1:0];
                mbet_pkg::CFG_LIMIT:
                    r_cfg.iteration_limit <= i_cfg.data[mbet_pkg::ITER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        qctl.push = push;
        qctl.pop  = pop;
    end

    mbet_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_pix.valid),
        .o_ready  (i_pix.ready),
        .i_column (i_pix.column),
        .i_row    (i_pix.row),
        .i_full   (q_full),
        .o_push   (push),
        .o_job    (front_job)
    );

    mbet_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (front_job),
        .o_job   (queue_job),
        .i_ctl   (qctl),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mbet_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_limit (r_cfg.iteration_limit),
        .i_empty (q_empty),
        .o_pop   (pop),
        .i_job   (queue_job),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_count (o_res.escape_count),
        .o_pix   (o_res.pixel_index)
    );
endmodule

// ===== src/mbet_front.sv =====
// Front end: accepts a pixel request, maps it to c with a bit-serial divider
// and forms the pixel index. Depends on mbet_pkg.
module mbet_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mbet_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [mbet_pkg::DIM_W-1:0]    i_column,
    input  logic [mbet_pkg::DIM_W-1:0]    i_row,
    input  logic                          i_full,
    output logic                          o_push,
    output mbet_pkg::t_job                o_job
);
    localparam int MW = mbet_pkg::MAG_W;
    localparam int SW = mbet_pkg::SIZE_W;
    localparam int PW = mbet_pkg::PROD_W;

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_MUL  = 4'b0010,
        F_DIV  = 4'b0100,
        F_PUSH = 4'b1000
    } t_fstate;

    t_fstate r_state, n_state;
    logic [mbet_pkg::DIM_W-1:0]  r_col, r_row;
    logic [MW-1:0]               r_nx, n_nx, r_ny, n_ny;
    logic [SW-1:0]               r_rx, n_rx, r_ry, n_ry;
    logic                        r_sx, r_sy;
    logic [mbet_pkg::PIX_W-1:0]  r_pix;
    logic [mbet_pkg::DCNT_W-1:0] r_cnt;

    logic signed [mbet_pkg::COORD_W:0] dx, dy;
    logic signed [MW:0]                px, py;
    logic [MW:0]                       ax, ay;
    logic [SW:0]                       tx, ty;
    logic signed [PW-1:0]              ox, oy;
    logic [2*mbet_pkg::DIM_W+1:0]      pix_full;

    always_comb begin
        dx = {i_cfg.x_end[31], i_cfg.x_end} - {i_cfg.x_start[31], i_cfg.x_start};
        dy = {i_cfg.y_end[31], i_cfg.y_end} - {i_cfg.y_start[31], i_cfg.y_start};
        px = (MW+1)'(dx * $signed({1'b0, r_col}));
        py = (MW+1)'(dy * $signed({1'b0, r_row}));
        ax = px[MW] ? (MW+1)'(-px) : px;
        ay = py[MW] ? (MW+1)'(-py) : py;
        pix_full = (2*mbet_pkg::DIM_W+2)'(r_col * i_cfg.image_height)
                 + (2*mbet_pkg::DIM_W+2)'(r_row);
    end

    always_comb begin
        tx = {r_rx, r_nx[MW-1]};
        ty = {r_ry, r_ny[MW-1]};
        n_rx = tx[SW-1:0];
        n_nx = {r_nx[MW-2:0], 1'b0};
        if (tx >= {1'b0, i_cfg.image_width}) begin
            n_rx = SW'(tx - {1'b0, i_cfg.image_width});
            n_nx[0] = 1'b1;
        end
        n_ry = ty[SW-1:0];
        n_ny = {r_ny[MW-2:0], 1'b0};
        if (ty >= {1'b0, i_cfg.image_height}) begin
            n_ry = SW'(ty - {1'b0, i_cfg.image_height});
            n_ny[0] = 1'b1;
        end
    end

    always_comb begin
        ox = PW'(0);
        oy = PW'(0);
        if (i_cfg.image_width != '0) begin
            ox = r_sx ? -PW'(r_nx) : PW'(r_nx);
        end
        if (i_cfg.image_height != '0) begin
            oy = r_sy ? -PW'(r_ny) : PW'(r_ny);
        end
        o_job.cx  = mbet_pkg::sat_coord(PW'(i_cfg.x_start) + ox);
        o_job.cy  = mbet_pkg::sat_coord(PW'(i_cfg.y_start) + oy);
        o_job.pix = r_pix;
    end

    assign o_ready = (r_state == F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_full;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_valid) n_state = F_MUL;
            F_MUL:  n_state = F_DIV;
            F_DIV:  if (r_cnt == mbet_pkg::DCNT_W'(mbet_pkg::DIV_STEPS-1)) n_state = F_PUSH;
            F_PUSH: if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                r_col <= i_column;
                r_row <= i_row;
            end
            F_MUL: begin
                r_nx  <= ax[MW-1:0];
                r_ny  <= ay[MW-1:0];
                r_sx  <= px[MW];
                r_sy  <= py[MW];
                r_rx  <= '0;
                r_ry  <= '0;
                r_cnt <= '0;
                r_pix <= pix_full[mbet_pkg::PIX_W-1:0];
            end
            F_DIV: begin
                r_nx  <= n_nx;
                r_ny  <= n_ny;
                r_rx  <= n_rx;
                r_ry  <= n_ry;
                r_cnt <= r_cnt + 1'b1;
            end
            F_PUSH: begin
            end
            default: begin
            end
        endcase
    end
endmodule

// ===== src/mbet_queue.sv =====
// Short queue of mapped jobs between the front and back ends.
// Depends on mbet_pkg.
module mbet_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mbet_pkg::t_job i_job,
    output mbet_pkg::t_job o_job,
    input  mbet_pkg::t_qctl i_ctl,
    output logic           o_full,
    output logic           o_empty
);
    mbet_pkg::t_job          r_mem [mbet_pkg::Q_DEPTH];
    logic [mbet_pkg::Q_AW-1:0] r_wp, r_rp;
    logic [mbet_pkg::Q_AW:0]   r_cnt;
    logic                      wr, rd;

    assign o_full  = (r_cnt == (mbet_pkg::Q_AW+1)'(mbet_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr      = i_ctl.push && !o_full;
    assign rd      = i_ctl.pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (mbet_pkg::Q_AW+1)'(wr) - (mbet_pkg::Q_AW+1)'(rd);
        end
    end
endmodule

// ===== src/mbet_back.sv =====
// Back end: iterates z = z^2 + c, a multiply then a test per iteration, and holds the
// result until taken. Depends on mbet_pkg.
module mbet_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [mbet_pkg::ITER_W-1:0]  i_limit,
    input  logic                         i_empty,
    output logic                         o_pop,
    input  mbet_pkg::t_job               i_job,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [mbet_pkg::ITER_W-1:0]  o_count,
    output logic [mbet_pkg::PIX_W-1:0]   o_pix
);
    localparam int PW = mbet_pkg::PROD_W;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MUL  = 4'b0010,
        B_TEST = 4'b0100,
        B_OUT  = 4'b1000
    } t_bstate;

    t_bstate r_state, n_state;
    logic signed [mbet_pkg::COORD_W-1:0] r_zx, r_zy, r_cx, r_cy;
    logic signed [PW-1:0]                r_xx, r_yy, r_xy;
    logic [mbet_pkg::ITER_W-1:0]         r_iter;
    logic [mbet_pkg::PIX_W-1:0]          r_pix;

    logic [PW-1:0]        mag;
    logic                 done;
    logic signed [PW-1:0] nx, ny;

    always_comb begin
        mag  = r_xx + r_yy;
        done = (|mag[PW-1:mbet_pkg::ESC_BIT]) || (r_iter >= i_limit);
        nx   = ((r_xx - r_yy) >>> mbet_pkg::FRAC_BITS) + PW'(r_cx);
        ny   = (r_xy >>> (mbet_pkg::FRAC_BITS-1)) + PW'(r_cy);
    end

    assign o_pop   = (r_state == B_IDLE) && !i_empty;
    assign o_valid = (r_state == B_OUT);
    assign o_pix   = r_pix;
    assign o_count = r_iter;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (!i_empty) n_state = B_MUL;
            B_MUL:  n_state = B_TEST;
            B_TEST: n_state = done ? B_OUT : B_MUL;
            B_OUT:  if (i_ready) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_zx   <= i_job.cx;
                r_zy   <= i_job.cy;
                r_cx   <= i_job.cx;
                r_cy   <= i_job.cy;
                r_pix  <= i_job.pix;
                r_iter <= '0;
            end
            B_MUL: begin
                r_xx <= PW'(r_zx) * PW'(r_zx);
                r_yy <= PW'(r_zy) * PW'(r_zy);
                r_xy <= PW'(r_zx) * PW'(r_zy);
            end
            B_TEST: begin
                if (done) begin
                    if (r_iter == i_limit) r_iter <= '0;
                end else begin
                    r_zx   <= mbet_pkg::sat_coord(nx);
                    r_zy   <= mbet_pkg::sat_coord(ny);
                    r_iter <= r_iter + 1'b1;
                end
            end
            B_OUT: begin
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_MUL) |-> (r_iter <= i_limit))
        else $error("iteration past limit");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == B_MUL))
        else $error("pop without start");
    a_test_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_TEST) |-> ($past(r_state) == B_MUL))
        else $error("test without products");
`endif
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for mandelbrot_escape_time: pixel requests, register writes,
// per-pixel escape-count prediction and in-order result checking.
// Depends on mbet_pkg, the mbet_*_if interfaces and the top level in src.
module tb;

    localparam int WATCHDOG = 400000;

    typedef struct packed {
        logic [mbet_pkg::DIM_W-1:0] column;
        logic [mbet_pkg::DIM_W-1:0] row;
    } t_pixel;

    typedef struct packed {
        logic [mbet_pkg::ITER_W-1:0] escape_count;
        logic [mbet_pkg::PIX_W-1:0]  pixel_index;
    } t_escape;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mbet_pix_if pix ();
    mbet_res_if res ();
    mbet_cfg_if cfg ();

    mandelbrot_escape_time i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pix  (pix.sink),
        .o_res  (res.source),
        .i_cfg  (cfg.sink)
    );

    always #5 i_clk = ~i_clk;

    t_pixel         pixel_q[$];
    t_escape        escape_q[$];
    mbet_pkg::t_cfg plane;
    int             idle_pct;
    int             stall_pct;
    int             mismatches;
    int             pixels_done;
    int             quiet_cycles;
    logic           pix_taken;
    logic           cfg_taken;

    function automatic logic signed [mbet_pkg::COORD_W-1:0] clamp_q(input longint v);
        if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
        if (v < -longint'(32'sh7fffffff) - 1) return 32'sh80000000;
        return v[mbet_pkg::COORD_W-1:0];
    endfunction

    function automatic logic signed [mbet_pkg::COORD_W-1:0] axis_point(
        input logic signed [mbet_pkg::COORD_W-1:0] lo,
        input logic signed [mbet_pkg::COORD_W-1:0] hi,
        input logic [mbet_pkg::DIM_W-1:0] idx, input logic [mbet_pkg::SIZE_W-1:0] size);
        longint span;
        span = 0;
        if (size != 0)
            span = (longint'(hi) - longint'(lo)) * longint'({1'b0, idx})
                   / longint'({1'b0, size});
        return clamp_q(longint'(lo) + span);
    endfunction

    function automatic t_escape escape_of(input t_pixel p, input mbet_pkg::t_cfg c);
        logic signed [mbet_pkg::COORD_W-1:0] cx, cy, zx, zy;
        longint xx, yy, nx, ny;
        logic [63:0] mag;
        int unsigned n;
        t_escape e;
        cx = axis_point(c.x_start, c.x_end, p.column, c.image_width);
        cy = axis_point(c.y_start, c.y_end, p.row, c.image_height);
        zx = cx;
        zy = cy;
        n = 0;
        forever begin
            xx = longint'(zx) * longint'(zx);
            yy = longint'(zy) * longint'(zy);
            mag = xx + yy;
            if (mag >= (64'd1 << mbet_pkg::ESC_BIT) || n >= c.iteration_limit) break;
            nx = ((xx - yy) >>> mbet_pkg::FRAC_BITS) + longint'(cx);
            ny = ((longint'(zx) * longint'(zy)) >>> (mbet_pkg::FRAC_BITS - 1))
                 + longint'(cy);
            zx = clamp_q(nx);
            zy = clamp_q(ny);
            n++;
        end
        if (n == c.iteration_limit) n = 0;
        e.escape_count = n[mbet_pkg::ITER_W-1:0];
        e.pixel_index = mbet_pkg::PIX_W'(p.column * c.image_height + p.row);
        return e;
    endfunction

    // sample all handshakes at the rising edge
    always @(posedge i_clk) begin
        t_escape want;
        pix_taken <= pix.valid && pix.ready;
        cfg_taken <= cfg.valid && cfg.ready;
        if (!i_rst_n) begin
            plane.x_start <= -32'sd536870912;
            plane.x_end <= 32'sd268435456;
            plane.y_start <= -32'sd402653184;
            plane.y_end <= 32'sd402653184;
            plane.image_width <= 13'd1024;
            plane.image_height <= 13'd1024;
            plane.iteration_limit <= 16'd256;
            quiet_cycles <= 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (mbet_pkg::t_cfg_idx'(cfg.index))
                    mbet_pkg::CFG_X_START: plane.x_start <= cfg.data;
                    mbet_pkg::CFG_X_END:   plane.x_end <= cfg.data;
                    mbet_pkg::CFG_Y_START: plane.y_start <= cfg.data;
                    mbet_pkg::CFG_Y_END:   plane.y_end <= cfg.data;
                    mbet_pkg::CFG_WIDTH:
                        plane.image_width <= cfg.data[mbet_pkg::SIZE_W-1:0];
                    mbet_pkg::CFG_HEIGHT:
                        plane.image_height <= cfg.data[mbet_pkg::SIZE_W-1:0];
                    mbet_pkg::CFG_LIMIT:
                        plane.iteration_limit <= cfg.data[mbet_pkg::ITER_W-1:0];
                    default: ;
                endcase
            end
            if (pix.valid && pix.ready)
                escape_q.push_back(escape_of({pix.column, pix.row}, plane));
            if (res.valid && res.ready) begin
                pixels_done++;
                if (escape_q.size() == 0) begin
                    $error("unexpected result: escape_count %0d pixel_index %0d",
                           res.escape_count, res.pixel_index);
                    mismatches++;
                end else begin
                    want = escape_q.pop_front();
                    if (res.escape_count !== want.escape_count) begin
                        $error("escape_count: expected %0d, got %0d",
                               want.escape_count, res.escape_count);
                        mismatches++;
                    end
                    if (res.pixel_index !== want.pixel_index) begin
                        $error("pixel_index: expected %0d, got %0d",
                               want.pixel_index, res.pixel_index);
                        mismatches++;
                    end
                end
            end
            if ((pix.valid && pix.ready) || (res.valid && res.ready)
                    || (cfg.valid && cfg.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG) begin
                $display("watchdog expired with %0d results outstanding", escape_q.size());
                $display("end of test: mismatches");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // drive requests and result back-pressure at the falling edge
    always @(negedge i_clk) begin
        t_pixel p;
        if (i_rst_n) begin
            if (pix_taken || !pix.valid) begin
                if (pixel_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    p = pixel_q.pop_front();
                    pix.valid <= 1'b1;
                    pix.column <= p.column;
                    pix.row <= p.row;
                end else begin
                    pix.valid <= 1'b0;
                end
            end
            res.ready <= $urandom_range(99) >= stall_pct;
        end
    end

    task automatic write_reg(input mbet_pkg::t_cfg_idx idx,
                             input logic [mbet_pkg::CDATA_W-1:0] value);
        @(negedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do @(negedge i_clk); while (!cfg_taken);
        cfg.valid <= 1'b0;
    endtask

    task automatic set_plane(input logic [31:0] xs, input logic [31:0] xe,
                             input logic [31:0] ys, input logic [31:0] ye,
                             input int w, input int h, input int lim);
        write_reg(mbet_pkg::CFG_X_START, xs);
        write_reg(mbet_pkg::CFG_X_END, xe);
        write_reg(mbet_pkg::CFG_Y_START, ys);
        write_reg(mbet_pkg::CFG_Y_END, ye);
        write_reg(mbet_pkg::CFG_WIDTH, w);
        write_reg(mbet_pkg::CFG_HEIGHT, h);
        write_reg(mbet_pkg::CFG_LIMIT, lim);
    endtask

    task automatic drain();
        do @(negedge i_clk);
        while (pixel_q.size() != 0 || pix.valid || escape_q.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic push_pixel(input int col, input int row);
        pixel_q.push_back({mbet_pkg::DIM_W'(col), mbet_pkg::DIM_W'(row)});
    endtask

    task automatic random_phase(input int mode, input int count, input bit pause);
        logic [31:0] xs, xe, ys, ye;
        int w, h, lim;
        case (mode)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 66; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 66; end
            default: begin idle_pct = 6; stall_pct = 6; end
        endcase
        if ($urandom_range(3) == 0) begin
            xs = $urandom; xe = $urandom; ys = $urandom; ye = $urandom;
        end else begin
            xs = $urandom_range(0, 805306368) - 671088640;
            xe = xs + $urandom_range(1 << 20, 1 << 30);
            ys = $urandom_range(0, 536870912) - 402653184;
            ye = ys + $urandom_range(1 << 20, 1 << 30);
        end
        w = ($urandom_range(7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 64);
        h = ($urandom_range(7) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 64);
        lim = ($urandom_range(9) == 0) ? $urandom_range(0, 300) : $urandom_range(1, 48);
        set_plane(xs, xe, ys, ye, w, h, lim);
        for (int k = 0; k < count; k++) begin
            if (pause && k == count / 2) drain();
            if ($urandom_range(9) == 0 || w == 0 || h == 0)
                push_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
            else
                push_pixel($urandom_range(0, (w > 4096 ? 4096 : w) - 1),
                           $urandom_range(0, (h > 4096 ? 4096 : h) - 1));
        end
        drain();
    endtask

    initial begin
        pix.valid = 1'b0;
        pix.column = '0;
        pix.row = '0;
        res.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        idle_pct = 0;
        stall_pct = 0;
        mismatches = 0;
        pixels_done = 0;
        pix_taken = 1'b0;
        cfg_taken = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset plane: corners, centre, beyond the image
        push_pixel(0, 0);
        push_pixel(4095, 4095);
        push_pixel(683, 512);
        push_pixel(512, 512);
        push_pixel(1023, 1023);
        push_pixel(2730, 1365);
        drain();
        // full-range plane: extreme coordinates that escape at once
        set_plane(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 8191, 1, 1);
        push_pixel(0, 0);
        push_pixel(4095, 4095);
        push_pixel(2048, 0);
        push_pixel(4095, 0);
        drain();
        // zero sizes give c = start; zero limit gives no iteration
        set_plane(32'h0, 32'h10000000, 32'h0, 32'h10000000, 0, 0, 0);
        push_pixel(4095, 4095);
        push_pixel(0, 0);
        drain();
        set_plane(32'hf8000000, 32'h04000000, 32'hfc000000, 32'h04000000, 4096, 4096, 1);
        push_pixel(2048, 2048);
        push_pixel(0, 4095);
        push_pixel(4095, 0);
        drain();
        // deepest limit: one point inside the set, one on the edge
        set_plane(32'h0, 32'h10000000, 32'h0, 32'h10000000, 16, 16, 65535);
        push_pixel(0, 0);
        push_pixel(4, 0);
        drain();

        for (int ph = 0; ph < 12; ph++)
            random_phase(ph % 4, 125, ph == 5);

        repeat (50) @(negedge i_clk);
        $display("covered %0d pixels over directed corner cases and 12 random planes",
                 pixels_done);
        $display("with sender gaps, result back-pressure and a full drain mid-phase");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
